[design/iir8_pkg.sv]
// Shared constants, codes and control types of the eighth-order IIR filter.
`default_nettype none

package iir8_pkg;

  // Filter shape and default parameter values
  localparam int FILTER_ORDER    = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 32;

  // Fixed number formats: x in Q16.16, y in Q24.16
  localparam int X_W       = 32;
  localparam int XS_W      = X_W + 1;     // sum of two x taps
  localparam int Y_W       = 40;
  localparam int Y_FRAC    = 16;
  localparam int IP_W      = Y_W - Y_FRAC;
  localparam int GAIN_W    = 32;
  localparam int GAIN_FRAC = 8;
  localparam int COEF_HALF = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_COEF   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_GAIN = 3'd0,
    CFG_B1_B2    = 3'd1,
    CFG_B3_B4    = 3'd2,
    CFG_A1_A2    = 3'd3,
    CFG_A3_A4    = 3'd4,
    CFG_A5_A6    = 3'd5,
    CFG_A7_A8    = 3'd6
  } cfg_idx_e;

  // Shared multiplier: the 40-bit operand is split into two 20-bit halves
  localparam int OPA_W  = 40;
  localparam int LO_W   = 20;
  localparam int MA_W   = OPA_W - LO_W + 1;
  localparam int MB_W   = 33;
  localparam int PP_W   = MA_W + MB_W;
  localparam int FULL_W = OPA_W + MB_W;
  localparam int ACC_W  = 48;

  // Product schedule: input scaling, four feed-forward, eight feedback
  localparam int N_TERMS = 13;
  localparam int TERM_W  = 4;
  localparam int SLOT_W  = 5;

  localparam logic [TERM_W-1:0] TERM_SCALE = 4'd0;
  localparam logic [TERM_W-1:0] TERM_B1    = 4'd1;
  localparam logic [TERM_W-1:0] TERM_B4    = 4'd4;
  localparam logic [TERM_W-1:0] TERM_A1    = 4'd5;
  localparam logic [TERM_W-1:0] TERM_LAST  = 4'd12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRAP
  } ctrl_state_e;

  typedef struct packed {
    logic              start;   // capture sample, seed accumulator
    logic              issue;   // launch one half-product
    logic [TERM_W-1:0] term;
    logic              hi;      // upper operand half
    logic              finish;  // write back history and result
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[design/iir8_in_if.sv]
// Input sample channel: valid/ready with sample and buffer-end flag.
`default_nettype none

interface iir8_in_if #(
  parameter int SAMPLE_BITS = iir8_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, sample_in, last_in, input ready);
  modport sink   (input valid, sample_in, last_in, output ready);
endinterface

`default_nettype wire

[design/iir8_out_if.sv]
// Output sample channel: valid/ready with filtered sample, clip and buffer-end flags.
`default_nettype none

interface iir8_out_if #(
  parameter int SAMPLE_BITS = iir8_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  logic                          last_out;

  modport source (output valid, sample_out, clipped, last_out, input ready);
  modport sink   (input valid, sample_out, clipped, last_out, output ready);
endinterface

`default_nettype wire

[design/iir8_ctrl.sv]
// Controller: sequences the product slots of one sample and owns the handshakes.
`default_nettype none

module iir8_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output iir8_pkg::dp_cmd_t      cmd_o,
  input  iir8_pkg::dp_status_t   status_i
);

  localparam logic [iir8_pkg::SLOT_W-1:0] LAST_SLOT =
    iir8_pkg::SLOT_W'(2 * iir8_pkg::N_TERMS - 1);

  iir8_pkg::ctrl_state_e         state_q, state_d;
  logic [iir8_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_free;
  logic                          do_finish;

  assign out_free  = !out_valid_q || out_ready_i;
  assign do_finish = (state_q == iir8_pkg::ST_WRAP) && !status_i.pipe_busy && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    unique case (state_q)
      iir8_pkg::ST_IDLE: begin
        slot_d = '0;
        if (in_valid_i) begin
          state_d = iir8_pkg::ST_MUL;
        end
      end
      iir8_pkg::ST_MUL: begin
        if (slot_q == LAST_SLOT) begin
          slot_d  = '0;
          state_d = iir8_pkg::ST_WRAP;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      iir8_pkg::ST_WRAP: begin
        if (do_finish) begin
          state_d = iir8_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iir8_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.term   = slot_q[iir8_pkg::SLOT_W-1:1];
    cmd_o.hi     = slot_q[0];
    unique case (state_q)
      iir8_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      iir8_pkg::ST_MUL: begin
        cmd_o.issue = 1'b1;
      end
      iir8_pkg::ST_WRAP: begin
        cmd_o.finish = do_finish;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iir8_pkg::ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[design/iir8_dp.sv]
// Datapath: registers, histories, shared split multiplier, accumulator, saturation.
`default_nettype none

module iir8_dp #(
  parameter int SAMPLE_BITS = iir8_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = iir8_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iir8_pkg::dp_cmd_t                     cmd_i,
  output iir8_pkg::dp_status_t                  status_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic                                  last_i,
  input  logic                                  cfg_we_i,
  input  logic [iir8_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [iir8_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_o,
  output logic                                  clip_o,
  output logic                                  last_o
);

  localparam int COEF_FRAC = COEF_BITS - 4;
  localparam int X_W   = iir8_pkg::X_W;
  localparam int Y_W   = iir8_pkg::Y_W;
  localparam int ACC_W = iir8_pkg::ACC_W;
  localparam int ORD   = iir8_pkg::FILTER_ORDER;

  // Configuration
  logic [iir8_pkg::GAIN_W-1:0]     inv_gain_q;
  logic [iir8_pkg::CFG_DATA_W-1:0] coef_q [iir8_pkg::NUM_COEF];

  // Histories and per-sample state
  logic signed [X_W-1:0]           xhist_q [ORD];
  logic signed [Y_W-1:0]           yhist_q [ORD];
  logic signed [SAMPLE_BITS-1:0]   s_q;
  logic                            last_q;
  logic signed [X_W-1:0]           x_new_q;
  logic signed [ACC_W-1:0]         acc_q;

  // Multiplier pipeline
  logic signed [iir8_pkg::XS_W-1:0]   xpair [1:3];
  logic signed [iir8_pkg::OPA_W-1:0]  op_a;
  logic signed [iir8_pkg::MB_W-1:0]   op_b;
  logic [iir8_pkg::COEF_HALF-1:0]     chalf;
  logic [iir8_pkg::TERM_W-1:0]        cidx;
  logic signed [iir8_pkg::MA_W-1:0]   mul_a;
  logic signed [iir8_pkg::PP_W-1:0]   pp_d, pp_q, lo_q;
  logic signed [iir8_pkg::FULL_W-1:0] full_q;
  logic                               v1_q, hi1_q, scale1_q;
  logic                               v2_q, scale2_q;

  // Accumulate and write back
  logic signed [ACC_W-1:0]         term_v;
  logic signed [ACC_W-1:0]         add_v;
  logic                            x_ovf;
  logic signed [X_W-1:0]           x_sat;
  logic                            y_ovf;
  logic signed [Y_W-1:0]           y_sat;
  logic signed [iir8_pkg::IP_W-1:0] ip;
  logic                            s_ovf;
  logic signed [SAMPLE_BITS-1:0]   s_sat;
  logic signed [SAMPLE_BITS-1:0]   out_sample_q;
  logic                            out_clip_q, out_last_q;

  // Symmetric feed-forward tap pairs
  always_comb begin
    for (int i = 1; i <= 3; i++) begin
      xpair[i] = iir8_pkg::XS_W'(xhist_q[i]) + iir8_pkg::XS_W'(xhist_q[ORD - i]);
    end
  end

  // Operand selection for the current term
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    chalf = '0;
    cidx  = cmd_i.term - iir8_pkg::TERM_B1;
    if (cmd_i.term == iir8_pkg::TERM_SCALE) begin
      op_a = iir8_pkg::OPA_W'(s_q);
      op_b = iir8_pkg::MB_W'({1'b0, inv_gain_q});
    end else if (cmd_i.term <= iir8_pkg::TERM_LAST) begin
      chalf = cidx[0] ? coef_q[cidx[3:1]][2*iir8_pkg::COEF_HALF-1:iir8_pkg::COEF_HALF]
                      : coef_q[cidx[3:1]][iir8_pkg::COEF_HALF-1:0];
      op_b  = iir8_pkg::MB_W'($signed(chalf[COEF_BITS-1:0]));
      if (cmd_i.term == iir8_pkg::TERM_B4) begin
        op_a = iir8_pkg::OPA_W'(xhist_q[ORD/2]);
      end else if (cmd_i.term < iir8_pkg::TERM_B4) begin
        op_a = iir8_pkg::OPA_W'(xpair[2'(cmd_i.term)]);
      end else begin
        op_a = iir8_pkg::OPA_W'(yhist_q[3'(cmd_i.term - iir8_pkg::TERM_A1)]);
      end
    end
  end

  // Upper half signed, lower half zero-extended
  assign mul_a = cmd_i.hi
               ? iir8_pkg::MA_W'($signed(op_a[iir8_pkg::OPA_W-1:iir8_pkg::LO_W]))
               : iir8_pkg::MA_W'({1'b0, op_a[iir8_pkg::LO_W-1:0]});
  assign pp_d  = iir8_pkg::PP_W'(mul_a) * iir8_pkg::PP_W'(op_b);

  // Floor shift of the full product, then clamp of the scaled sample
  assign term_v = scale2_q ? ACC_W'(full_q >>> iir8_pkg::GAIN_FRAC)
                           : ACC_W'(full_q >>> COEF_FRAC);
  assign x_ovf  = !(&term_v[ACC_W-1:X_W-1] || ~|term_v[ACC_W-1:X_W-1]);
  assign x_sat  = x_ovf ? {term_v[ACC_W-1], {(X_W-1){~term_v[ACC_W-1]}}}
                        : term_v[X_W-1:0];
  assign add_v  = scale2_q ? ACC_W'(x_sat) : term_v;

  // New output: clamp to Q24.16, floor to integer, saturate to sample width
  assign y_ovf = !(&acc_q[ACC_W-1:Y_W-1] || ~|acc_q[ACC_W-1:Y_W-1]);
  assign y_sat = y_ovf ? {acc_q[ACC_W-1], {(Y_W-1){~acc_q[ACC_W-1]}}}
                       : acc_q[Y_W-1:0];
  assign ip    = y_sat[Y_W-1:iir8_pkg::Y_FRAC];
  assign s_ovf = !(&ip[iir8_pkg::IP_W-1:SAMPLE_BITS-1] || ~|ip[iir8_pkg::IP_W-1:SAMPLE_BITS-1]);
  assign s_sat = s_ovf ? {ip[iir8_pkg::IP_W-1], {(SAMPLE_BITS-1){~ip[iir8_pkg::IP_W-1]}}}
                       : ip[SAMPLE_BITS-1:0];

  assign status_o.pipe_busy = v1_q || v2_q;

  // Control, configuration and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_gain_q <= iir8_pkg::GAIN_W'(32'h0100_0000);
      for (int i = 0; i < iir8_pkg::NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
      for (int i = 0; i < ORD; i++) begin
        xhist_q[i] <= '0;
        yhist_q[i] <= '0;
      end
      v1_q     <= 1'b0;
      hi1_q    <= 1'b0;
      scale1_q <= 1'b0;
      v2_q     <= 1'b0;
      scale2_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (iir8_pkg::cfg_idx_e'(cfg_idx_i))
          iir8_pkg::CFG_INV_GAIN: inv_gain_q <= cfg_data_i[iir8_pkg::GAIN_W-1:0];
          iir8_pkg::CFG_B1_B2:    coef_q[0]  <= cfg_data_i;
          iir8_pkg::CFG_B3_B4:    coef_q[1]  <= cfg_data_i;
          iir8_pkg::CFG_A1_A2:    coef_q[2]  <= cfg_data_i;
          iir8_pkg::CFG_A3_A4:    coef_q[3]  <= cfg_data_i;
          iir8_pkg::CFG_A5_A6:    coef_q[4]  <= cfg_data_i;
          iir8_pkg::CFG_A7_A8:    coef_q[5]  <= cfg_data_i;
          default: ;
        endcase
      end
      v1_q     <= cmd_i.issue;
      hi1_q    <= cmd_i.hi;
      scale1_q <= (cmd_i.term == iir8_pkg::TERM_SCALE);
      v2_q     <= v1_q && hi1_q;
      scale2_q <= scale1_q;
      if (cmd_i.finish) begin
        for (int i = 0; i < ORD - 1; i++) begin
          xhist_q[i] <= xhist_q[i+1];
          yhist_q[i] <= yhist_q[i+1];
        end
        xhist_q[ORD-1] <= x_new_q;
        yhist_q[ORD-1] <= y_sat;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      s_q    <= sample_i;
      last_q <= last_i;
      acc_q  <= ACC_W'(xhist_q[0]);
    end else if (v2_q) begin
      acc_q <= acc_q + add_v;
    end
    if (v2_q && scale2_q) begin
      x_new_q <= x_sat;
    end
    if (cmd_i.issue) begin
      pp_q <= pp_d;
    end
    if (v1_q && !hi1_q) begin
      lo_q <= pp_q;
    end
    if (v1_q && hi1_q) begin
      full_q <= (iir8_pkg::FULL_W'(pp_q) <<< iir8_pkg::LO_W) + iir8_pkg::FULL_W'(lo_q);
    end
    if (cmd_i.finish) begin
      out_sample_q <= s_sat;
      out_clip_q   <= s_ovf;
      out_last_q   <= last_q;
    end
  end

  assign sample_o = out_sample_q;
  assign clip_o   = out_clip_q;
  assign last_o   = out_last_q;

endmodule

`default_nettype wire

[design/iir_order8_symmetric_filter.sv]
// Top level of the eighth-order direct-form-I IIR filter with symmetric feed-forward.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-----------------------------------
//   in_s     | sink      | valid / ready    | sample_in, last_in
//   out_m    | source    | valid / ready    | sample_out, clipped, last_out
//   cfg      | sink      | cfg_we_i only    | cfg_idx_i, cfg_data_i (64 bits)
//
// Sequence: each sample is accepted, then worked on the single 21x33 multiplier
//   as 13 products, each taken as two 20-bit operand halves; the multiplier pipeline
//   then drains and the result is written back. A new sample is taken only after
//   write-back. The shared multiplier limits the sample rate.
// Stalls: a finished result waits in the output register while the next
//   sample is taken and worked on; write-back holds while that result is unclaimed.
// Reset: both histories clear, inv_gain returns to 1.0 and all weights to zero.
`default_nettype none

module iir_order8_symmetric_filter #(
  parameter int SAMPLE_BITS = iir8_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = iir8_pkg::COEF_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  iir8_in_if.sink                           in_s,
  iir8_out_if.source                        out_m,
  input  logic                              cfg_we_i,
  input  logic [iir8_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [iir8_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  iir8_pkg::dp_cmd_t    cmd;
  iir8_pkg::dp_status_t status;

  // Sequencer: one transaction in, product slots, drain, write-back
  iir8_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Arithmetic, histories, weights and the output register
  iir8_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .sample_i   (in_s.sample_in),
    .last_i     (in_s.last_in),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_o   (out_m.sample_out),
    .clip_o     (out_m.clipped),
    .last_o     (out_m.last_out)
  );

endmodule

`default_nettype wire

[design/iir8_checker.sv]
// Port-level checker for the IIR filter, bound to the top level.
`default_nettype none

module iir8_checker #(
  parameter int SAMPLE_BITS = iir8_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_clipped,
  input logic                   out_last
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Transactions taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_clipped)
                                && $stable(out_last))
    else $error("stalled output payload changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready)
    else $error("input taken while a sample is in work");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 2'd0)
    else $error("result offered with no sample outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two samples outstanding");

endmodule

bind iir_order8_symmetric_filter iir8_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_iir8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_s.valid),
  .in_ready    (in_s.ready),
  .out_valid   (out_m.valid),
  .out_ready   (out_m.ready),
  .out_sample  (out_m.sample_out),
  .out_clipped (out_m.clipped),
  .out_last    (out_m.last_out)
);

`default_nettype wire

[dv/iir_order8_symmetric_filter_checker.sv]
// Transaction monitor and filter predictor for the eighth-order IIR filter.
`default_nettype none

module iir_order8_symmetric_filter_checker
  import iir8_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iir8_in_if                    in_w,
  iir8_out_if                   out_w,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int     COEF_FRAC   = COEF_BITS - 4;
  localparam longint X_MAX       = (longint'(1) <<< (X_W - 1)) - 1;
  localparam longint X_MIN       = -(longint'(1) <<< (X_W - 1));
  localparam longint Y_MAX       = (longint'(1) <<< (Y_W - 1)) - 1;
  localparam longint Y_MIN       = -(longint'(1) <<< (Y_W - 1));
  localparam longint S_MAX       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint S_MIN       = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
    logic                          last;
  } filt_result_t;

  filt_result_t        predicted_out_q[$];
  logic [GAIN_W-1:0]   gain_q;
  logic [CFG_DATA_W-1:0] weight_regs_q [NUM_COEF];
  longint              x_hist [FILTER_ORDER];
  longint              y_hist [FILTER_ORDER];
  int                  err_cnt;

  // floor(a * c / 2^sh)
  function automatic longint floor_scale(longint a, longint c, int sh);
    logic signed [127:0] pa, pc, prod;
    pa   = a;
    pc   = c;
    prod = pa * pc;
    return longint'(prod >>> sh);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // signed weight from half h of weight register r, low COEF_BITS bits only
  function automatic longint weight(int r, int h);
    logic [COEF_HALF-1:0] half;
    longint               v;
    half = weight_regs_q[r][COEF_HALF*h +: COEF_HALF];
    v    = longint'({32'd0, half}) & ((longint'(1) <<< COEF_BITS) - 1);
    if (v[COEF_BITS-1]) v -= longint'(1) <<< COEF_BITS;
    return v;
  endfunction

  function automatic filt_result_t predict_output(logic signed [SAMPLE_BITS-1:0] s, logic l);
    longint       xs [FILTER_ORDER+1];
    longint       acc, y, ip;
    filt_result_t r;
    for (int i = 0; i < FILTER_ORDER; i++) xs[i] = x_hist[i];
    xs[FILTER_ORDER] = clamp(floor_scale(longint'(s), longint'({32'd0, gain_q}), GAIN_FRAC),
                             X_MIN, X_MAX);
    acc = xs[0] + xs[8];
    acc += floor_scale(xs[1] + xs[7], weight(0, 0), COEF_FRAC);
    acc += floor_scale(xs[2] + xs[6], weight(0, 1), COEF_FRAC);
    acc += floor_scale(xs[3] + xs[5], weight(1, 0), COEF_FRAC);
    acc += floor_scale(xs[4], weight(1, 1), COEF_FRAC);
    for (int i = 0; i < FILTER_ORDER; i++)
      acc += floor_scale(y_hist[i], weight(2 + i / 2, i % 2), COEF_FRAC);
    y = clamp(acc, Y_MIN, Y_MAX);
    for (int i = 0; i < FILTER_ORDER - 1; i++) begin
      x_hist[i] = x_hist[i+1];
      y_hist[i] = y_hist[i+1];
    end
    x_hist[FILTER_ORDER-1] = xs[FILTER_ORDER];
    y_hist[FILTER_ORDER-1] = y;
    ip        = y >>> Y_FRAC;
    r.clipped = 1'b0;
    if (ip > S_MAX) begin
      ip        = S_MAX;
      r.clipped = 1'b1;
    end else if (ip < S_MIN) begin
      ip        = S_MIN;
      r.clipped = 1'b1;
    end
    r.sample = ip[SAMPLE_BITS-1:0];
    r.last   = l;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_result_t exp_r;
    if (!rst_ni) begin
      gain_q = GAIN_W'(32'h0100_0000);
      for (int i = 0; i < NUM_COEF; i++) weight_regs_q[i] = '0;
      for (int i = 0; i < FILTER_ORDER; i++) begin
        x_hist[i] = 0;
        y_hist[i] = 0;
      end
      predicted_out_q.delete();
      err_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INV_GAIN) gain_q = cfg_data_i[GAIN_W-1:0];
        else if (cfg_idx_i <= CFG_A7_A8) weight_regs_q[cfg_idx_i - CFG_B1_B2] = cfg_data_i;
      end
      if (out_w.valid && out_w.ready) begin
        if (predicted_out_q.size() == 0) begin
          $error("unexpected output: sample_out %0d clipped %0b last_out %0b",
                 out_w.sample_out, out_w.clipped, out_w.last_out);
          err_cnt++;
        end else begin
          exp_r = predicted_out_q.pop_front();
          if (out_w.sample_out !== exp_r.sample) begin
            $error("sample_out: expected %0d, actual %0d", exp_r.sample, out_w.sample_out);
            err_cnt++;
          end
          if (out_w.clipped !== exp_r.clipped) begin
            $error("clipped: expected %0b, actual %0b", exp_r.clipped, out_w.clipped);
            err_cnt++;
          end
          if (out_w.last_out !== exp_r.last) begin
            $error("last_out: expected %0b, actual %0b", exp_r.last, out_w.last_out);
            err_cnt++;
          end
        end
      end
      if (in_w.valid && in_w.ready)
        predicted_out_q.push_back(predict_output(in_w.sample_in, in_w.last_in));
    end
    errors_o  <= err_cnt;
    pending_o <= predicted_out_q.size();
  end

endmodule

`default_nettype wire

[dv/iir_order8_symmetric_filter_test.sv]
// Stimulus, pacing and verdict for the eighth-order IIR filter testbench.
`default_nettype none

module iir_order8_symmetric_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iir8_pkg::*;

  // Register index beyond the last weight register: writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam int N_SETTINGS      = 8;
  localparam int N_PACINGS       = 4;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int N_DIRECTED      = 20;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT  = 3000;

  // Pacing per phase: none, sender idle, receiver stalling, both
  localparam int SRC_IDLE_PCT  [N_PACINGS] = '{0, 74, 0, 31};
  localparam int SNK_STALL_PCT [N_PACINGS] = '{0, 0, 74, 31};

  // Full-scale pairs eight apart clip high and low at unity gain
  localparam logic signed [15:0] DIRECTED_SAMPLES [N_DIRECTED] = '{
    16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh8000,
    16'sh5555, 16'shAAAA, 16'sh0000, 16'sh0000, 16'sh0000,
    16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA,
    16'sh0064, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    outstanding;
  int                    src_idle_pct;
  int                    snk_stall_pct;
  int                    quiet_cycles;

  iir8_in_if  in_ch ();
  iir8_out_if out_ch ();

  iir_order8_symmetric_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_ch),
    .out_m      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  iir_order8_symmetric_filter_checker response_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_w       (in_ch),
    .out_w      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (mismatch_count),
    .pending_o  (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stall at random with the current phase's rate
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: count cycles without any transaction, give up at the limit
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Signed random weight in [-2^mag, 2^mag], Q4.28 raw bits
  function automatic logic [COEF_HALF-1:0] rand_weight(int mag);
    int v;
    v = int'($urandom_range(2 ** (mag + 1))) - 2 ** mag;
    return COEF_HALF'(v);
  endfunction

  // Mostly fully random values, some small audio-like values, some full-scale
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: return 16'(int'($urandom_range(1024)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  // Present one sample; hold it until the transaction completes.
  // Leaves valid high so a following sample can go out back to back.
  task automatic send_sample(input logic signed [15:0] s, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.last_in   <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Drain the filter, then load a full register set
  task automatic program_setting(input int k);
    logic [GAIN_W-1:0]     gain;
    logic [CFG_DATA_W-1:0] w [NUM_COEF];
    int                    r;
    in_ch.valid <= 1'b0;
    // advance one edge first so an acceptance on this edge shows in the count
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (r = 0; r < NUM_COEF; r++) w[r] = '0;
    case (k)
      0: begin  // pure FIR at unity gain
        gain = 32'h0100_0000;
        w[0] = {rand_weight(28), rand_weight(28)};
        w[1] = {rand_weight(28), rand_weight(28)};
      end
      1: begin  // mild feedback: total feedback weight below one keeps it stable
        gain = 32'h0080_0000;
        w[0] = {rand_weight(26), rand_weight(26)};
        w[1] = {rand_weight(26), rand_weight(26)};
        for (r = 2; r < NUM_COEF; r++) w[r] = {rand_weight(24), rand_weight(24)};
      end
      2: begin  // largest gain and weights: input and accumulator both saturate
        gain = 32'hFFFF_FFFF;
        for (r = 0; r < NUM_COEF; r++) w[r] = {2{32'h7FFF_FFFF}};
      end
      3: begin  // smallest nonzero gain, most negative weights
        gain = 32'h0000_0001;
        for (r = 0; r < NUM_COEF; r++) w[r] = {2{32'h8000_0000}};
      end
      4: begin  // anything goes
        gain = $urandom();
        for (r = 0; r < NUM_COEF; r++) w[r] = {$urandom(), $urandom()};
      end
      5: begin  // zero gain: output is only the decaying history
        gain = '0;
        w[0] = {rand_weight(28), rand_weight(28)};
        w[1] = {rand_weight(28), rand_weight(28)};
        for (r = 2; r < NUM_COEF; r++) w[r] = {rand_weight(24), rand_weight(24)};
      end
      6: begin  // random gain on a stable filter
        gain = $urandom();
        w[0] = {rand_weight(27), rand_weight(27)};
        w[1] = {rand_weight(27), rand_weight(27)};
        for (r = 2; r < NUM_COEF; r++) w[r] = {rand_weight(24), rand_weight(24)};
      end
      default: begin  // back to reset values
        gain = 32'h0100_0000;
      end
    endcase
    // upper data bits are random: the gain register keeps only its low 32
    write_reg(CFG_INV_GAIN, {$urandom(), gain});
    for (r = 0; r < NUM_COEF; r++) write_reg(CFG_IDX_W'(CFG_B1_B2 + r), w[r]);
    // a write to the unused index must leave every register alone
    if (k % 2 == 1) write_reg(CFG_IDX_UNUSED, {$urandom(), $urandom()});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int i, k, p;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.last_in   = 1'b0;
    out_ch.ready    = 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    quiet_cycles    = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (unity gain, no weights), y = x[n] + x[n-8]
    for (i = 0; i < N_DIRECTED; i++) send_sample(DIRECTED_SAMPLES[i], (i % 5 == 4));

    // Random: every register set under every pacing
    for (k = 0; k < N_SETTINGS; k++) begin
      program_setting(k);
      for (p = 0; p < N_PACINGS; p++) begin
        src_idle_pct  = SRC_IDLE_PCT[p];
        snk_stall_pct = SNK_STALL_PCT[p];
        repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), ($urandom_range(15) == 0));
      end
    end

    // Drop valid, let every result drain, then watch for strays
    in_ch.valid   <= 1'b0;
    snk_stall_pct = 0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
